// ===== sv/sstab_pkg.sv =====
// Shared types, request codes and constants for the sorted set table.
package sstab_pkg;

    localparam int KEY_BITS      = 32;
    localparam int COUNT_BITS    = 7;
    localparam int DEF_CAPACITY  = 64;
    localparam int DEF_KEY_WIDTH = 32;

    typedef enum logic [2:0] {
        REQ_INSERT   = 3'd0,
        REQ_DELETE   = 3'd1,
        REQ_RETRIEVE = 3'd2,
        REQ_REWIND   = 3'd3,
        REQ_NEXT     = 3'd4,
        REQ_CLEAR    = 3'd5
    } t_req_type;

    typedef struct packed {
        logic [2:0]          req_type;
        logic [KEY_BITS-1:0] key;
    } t_request;

    typedef struct packed {
        logic                  ok;
        logic                  removed_count;
        logic [KEY_BITS-1:0]   item_out;
        logic [COUNT_BITS-1:0] entry_count;
        logic                  table_full;
    } t_result;

    typedef struct packed {
        logic capture;
        logic exec;
        logic ins;
        logic del;
        logic find;
        logic rewind;
        logic next;
        logic clear;
    } t_cmd;

endpackage

// ===== sv/sstab_ctrl.sv =====
// Controller: accepts a request, decodes its kind and runs it in the execute state.
module sstab_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [2:0]          i_req_type,
    output logic                busy,
    output sstab_pkg::t_cmd     o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } t_state;

    t_state     r_state, n_state;
    logic [2:0] r_req_type;
    logic       accept;

    assign busy   = (r_state == ST_EXEC);
    assign accept = start && !busy;

    always_comb begin
        case (r_state)
            ST_IDLE: n_state = accept ? ST_EXEC : ST_IDLE;
            ST_EXEC: n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req_type <= i_req_type;
        end
    end

    always_comb begin
        o_cmd         = '0;
        o_cmd.capture = accept;
        o_cmd.exec    = busy;
        if (busy) begin
            case (r_req_type)
                sstab_pkg::REQ_INSERT:   o_cmd.ins    = 1'b1;
                sstab_pkg::REQ_DELETE:   o_cmd.del    = 1'b1;
                sstab_pkg::REQ_RETRIEVE: o_cmd.find   = 1'b1;
                sstab_pkg::REQ_REWIND:   o_cmd.rewind = 1'b1;
                sstab_pkg::REQ_NEXT:     o_cmd.next   = 1'b1;
                sstab_pkg::REQ_CLEAR:    o_cmd.clear  = 1'b1;
                default: ;
            endcase
        end
    end

endmodule

// ===== sv/sstab_dp.sv =====
// Datapath: shifting cell array with parallel compare, count, cursor and result register.
module sstab_dp #(
    parameter int CAPACITY  = sstab_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = sstab_pkg::DEF_KEY_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sstab_pkg::t_cmd                   i_cmd,
    input  logic [sstab_pkg::KEY_BITS-1:0]    i_key,
    output logic                              o_done,
    output sstab_pkg::t_result                o_result
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int KB = sstab_pkg::KEY_BITS;
    localparam int NB = sstab_pkg::COUNT_BITS;

    logic [KEY_WIDTH-1:0] r_key, k_in;
    logic [KEY_WIDTH-1:0] r_cell [CAPACITY];
    logic [KEY_WIDTH-1:0] n_cell [CAPACITY];
    logic [CAPACITY-1:0]  vld, lt, eq;
    logic [CW-1:0]        r_count, n_count, r_cursor, n_cursor;
    logic [KEY_WIDTH-1:0] cur_entry;
    logic [KB-1:0]        cur_item;
    logic [NB-1:0]        cnt_out;
    logic                 found, has_room, ins_go, del_go, next_ok;
    logic                 r_done;
    sstab_pkg::t_result   r_res, n_res;

    generate
        if (KEY_WIDTH > KB) begin : g_key_wide
            assign k_in     = {{(KEY_WIDTH-KB){1'b0}}, i_key};
            assign cur_item = cur_entry[KB-1:0];
        end else if (KEY_WIDTH == KB) begin : g_key_same
            assign k_in     = i_key;
            assign cur_item = cur_entry;
        end else begin : g_key_narrow
            assign k_in     = i_key[KEY_WIDTH-1:0];
            assign cur_item = {{(KB-KEY_WIDTH){1'b0}}, cur_entry};
        end
        if (CW >= NB) begin : g_cnt_wide
            assign cnt_out = n_count[NB-1:0];
        end else begin : g_cnt_narrow
            assign cnt_out = {{(NB-CW){1'b0}}, n_count};
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_key <= k_in;
        end
    end

    assign found    = |eq;
    assign has_room = (r_count < CW'(CAPACITY));
    assign ins_go   = i_cmd.ins && !found && has_room;
    assign del_go   = i_cmd.del && found;
    assign next_ok  = i_cmd.next && (r_cursor < r_count);

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            assign vld[g] = (r_count > CW'(g));
            assign lt[g]  = vld[g] && (r_cell[g] < r_key);
            assign eq[g]  = vld[g] && (r_cell[g] == r_key);

            always_comb begin
                n_cell[g] = r_cell[g];
                if (ins_go && !lt[g]) begin
                    if (g == 0) begin
                        n_cell[g] = r_key;
                    end else begin
                        n_cell[g] = lt[(g == 0) ? 0 : g-1] ? r_key
                                                           : r_cell[(g == 0) ? 0 : g-1];
                    end
                end else if (del_go && !lt[g]) begin
                    if (g != CAPACITY-1) begin
                        n_cell[g] = r_cell[(g == CAPACITY-1) ? g : g+1];
                    end
                end
            end

            always_ff @(posedge i_clk) begin
                r_cell[g] <= n_cell[g];
            end
        end
    endgenerate

    assign cur_entry = r_cell[r_cursor[IW-1:0]];

    always_comb begin
        n_count  = r_count;
        n_cursor = r_cursor;
        if (i_cmd.clear) begin
            n_count  = '0;
            n_cursor = '0;
        end else if (ins_go) begin
            n_count = r_count + CW'(1);
        end else if (del_go) begin
            n_count = r_count - CW'(1);
        end else if (i_cmd.rewind) begin
            n_cursor = '0;
        end else if (next_ok) begin
            n_cursor = r_cursor + CW'(1);
        end
    end

    always_comb begin
        n_res.ok            = ins_go || del_go || (i_cmd.find && found) || next_ok;
        n_res.removed_count = del_go;
        n_res.item_out      = next_ok ? cur_item : '0;
        n_res.entry_count   = cnt_out;
        n_res.table_full    = (n_count == CW'(CAPACITY));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_cursor <= '0;
            r_done   <= 1'b0;
        end else begin
            r_done <= i_cmd.exec;
            if (i_cmd.exec) begin
                r_count  <= n_count;
                r_cursor <= n_cursor;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    assign o_done   = r_done;
    assign o_result = r_res;

endmodule

// ===== sv/sorted_set_table_top.sv =====
// Top level of the sorted set table: controller, cell-array datapath and checks.
// An accepted item is executed in the cycle after it is taken; its result strobes on o_done
// in the cycle after the execute cycle.
// A new item is not taken while the controller is busy in its execute state.
// Reset: synchronous, active low; empties the table and moves the cursor to the start.
// Results are shown for one cycle only; the receiver cannot stall.
module sorted_set_table_top #(
    parameter int CAPACITY  = sstab_pkg::DEF_CAPACITY,
    parameter int KEY_WIDTH = sstab_pkg::DEF_KEY_WIDTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    input  sstab_pkg::t_request i_request,
    output logic               busy,
    output logic               o_done,
    output sstab_pkg::t_result o_result
);

    sstab_pkg::t_cmd cmd;

    sstab_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .i_req_type (i_request.req_type),
        .busy       (busy),
        .o_cmd      (cmd)
    );

    sstab_dp #(
        .CAPACITY  (CAPACITY),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_key    (i_request.key),
        .o_done   (o_done),
        .o_result (o_result)
    );

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not enter execute");

    a_single_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |=> (!busy && o_done))
        else $error("execute did not finish with a result strobe");

    a_done_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result strobe without a preceding execute cycle");

    a_remove_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.removed_count) |-> o_result.ok)
        else $error("removal reported without ok");

endmodule

// ===== dv/sorted_set_table_top_tb.sv =====
// Testbench for the sorted set table: directed and random items checked against a shadow table.
`timescale 1ns / 100ps

module sorted_set_table_top_tb;

    localparam int CAPACITY      = sstab_pkg::DEF_CAPACITY;
    localparam int ITEM_TARGET   = 1950;
    localparam int STALL_LIMIT   = 4000;
    localparam int REPORT_LIMIT  = 10;
    localparam logic [2:0] REQ_SPARE_6 = 3'd6;
    localparam logic [2:0] REQ_SPARE_7 = 3'd7;

    typedef struct {
        sstab_pkg::t_request req;
        sstab_pkg::t_result  res;
    } t_pending;

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    sstab_pkg::t_request i_request;
    logic                busy;
    logic                o_done;
    sstab_pkg::t_result  o_result;

    logic [sstab_pkg::KEY_BITS-1:0] shadow_keys [CAPACITY];
    int                             shadow_count;
    int                             shadow_cursor;

    t_pending pending_results [$];
    int       mismatches;
    int       items_sent;
    int       idle_cycles;
    bit       no_idle;

    sorted_set_table_top DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .i_request (i_request),
        .busy      (busy),
        .o_done    (o_done),
        .o_result  (o_result)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic sstab_pkg::t_result table_apply(logic [2:0] req,
                                                       logic [sstab_pkg::KEY_BITS-1:0] key);
        sstab_pkg::t_result res;
        int                 pos;
        int                 i;
        bit                 hit;
        res = '0;
        pos = 0;
        while (pos < shadow_count && shadow_keys[pos] < key)
            pos++;
        hit = (pos < shadow_count) && (shadow_keys[pos] == key);
        case (req)
            sstab_pkg::REQ_INSERT: begin
                if (!hit && shadow_count < CAPACITY) begin
                    for (i = shadow_count; i > pos; i--)
                        shadow_keys[i] = shadow_keys[i-1];
                    shadow_keys[pos] = key;
                    shadow_count++;
                    res.ok = 1'b1;
                end
            end
            sstab_pkg::REQ_DELETE: begin
                if (hit) begin
                    for (i = pos; i < shadow_count - 1; i++)
                        shadow_keys[i] = shadow_keys[i+1];
                    shadow_count--;
                    res.ok = 1'b1;
                    res.removed_count = 1'b1;
                end
            end
            sstab_pkg::REQ_RETRIEVE: begin
                res.ok = hit;
            end
            sstab_pkg::REQ_REWIND: begin
                shadow_cursor = 0;
            end
            sstab_pkg::REQ_NEXT: begin
                if (shadow_cursor < shadow_count) begin
                    res.item_out = shadow_keys[shadow_cursor];
                    shadow_cursor++;
                    res.ok = 1'b1;
                end
            end
            sstab_pkg::REQ_CLEAR: begin
                shadow_count  = 0;
                shadow_cursor = 0;
            end
            default: ;
        endcase
        res.entry_count = shadow_count[sstab_pkg::COUNT_BITS-1:0];
        res.table_full  = (shadow_count == CAPACITY);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    task automatic send_request(input logic [2:0] req,
                                input logic [sstab_pkg::KEY_BITS-1:0] key);
        int       gap;
        t_pending p;
        gap = pick_gap();
        if (gap > 0) begin
            start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start              = 1'b1;
        i_request.req_type = req;
        i_request.key      = key;
        do
            @(posedge i_clk);
        while (busy);
        p.req = i_request;
        p.res = table_apply(req, key);
        pending_results.push_back(p);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input sstab_pkg::t_request req,
                                   input sstab_pkg::t_result exp_res,
                                   input sstab_pkg::t_result act_res);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%0t mismatch (%s) req=%0d key=%h exp ok=%b rm=%b item=%h cnt=%0d full=%b",
                     $time, what, req.req_type, req.key,
                     exp_res.ok, exp_res.removed_count, exp_res.item_out,
                     exp_res.entry_count, exp_res.table_full);
            $display("    act ok=%b rm=%b item=%h cnt=%0d full=%b",
                     act_res.ok, act_res.removed_count, act_res.item_out,
                     act_res.entry_count, act_res.table_full);
        end
    endtask

    always @(posedge i_clk) begin
        t_pending p;
        if (i_rst_n && o_done === 1'b1) begin
            if (pending_results.size() == 0) begin
                p.req = '0;
                p.res = '0;
                report_mismatch("unexpected result", p.req, p.res, o_result);
            end else begin
                p = pending_results.pop_front();
                if (o_result.ok !== p.res.ok
                        || o_result.removed_count !== p.res.removed_count
                        || o_result.item_out !== p.res.item_out
                        || o_result.entry_count !== p.res.entry_count
                        || o_result.table_full !== p.res.table_full)
                    report_mismatch("field", p.req, p.res, o_result);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_done === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    task automatic test_directed_cases();
        no_idle = 1'b0;
        send_request(sstab_pkg::REQ_NEXT, 32'h0000_0000);
        send_request(sstab_pkg::REQ_RETRIEVE, 32'h1234_5678);
        send_request(sstab_pkg::REQ_DELETE, 32'hFFFF_FFFF);
        send_request(sstab_pkg::REQ_CLEAR, 32'hFFFF_FFFF);
        send_request(sstab_pkg::REQ_INSERT, 32'hFFFF_FFFF);
        send_request(sstab_pkg::REQ_INSERT, 32'h0000_0000);
        send_request(sstab_pkg::REQ_INSERT, 32'h8000_0000);
        send_request(sstab_pkg::REQ_INSERT, 32'h5555_5555);
        send_request(sstab_pkg::REQ_INSERT, 32'hAAAA_AAAA);
        send_request(sstab_pkg::REQ_INSERT, 32'h8000_0000);
        send_request(sstab_pkg::REQ_RETRIEVE, 32'hFFFF_FFFF);
        send_request(sstab_pkg::REQ_RETRIEVE, 32'h0000_0001);
        send_request(sstab_pkg::REQ_REWIND, 32'hDEAD_BEEF);
        send_request(sstab_pkg::REQ_NEXT, 32'hFFFF_FFFF);
        send_request(sstab_pkg::REQ_NEXT, 32'h0000_0000);
        send_request(sstab_pkg::REQ_INSERT, 32'h0000_0001);
        send_request(sstab_pkg::REQ_NEXT, 32'h0000_0000);
        send_request(sstab_pkg::REQ_DELETE, 32'h0000_0000);
        send_request(sstab_pkg::REQ_DELETE, 32'h0000_0000);
        send_request(sstab_pkg::REQ_NEXT, 32'h0000_0000);
        send_request(sstab_pkg::REQ_NEXT, 32'h0000_0000);
        send_request(sstab_pkg::REQ_NEXT, 32'h0000_0000);
        send_request(REQ_SPARE_6, 32'hFFFF_FFFF);
        send_request(REQ_SPARE_7, 32'h0000_0000);
        send_request(sstab_pkg::REQ_CLEAR, 32'h0000_0000);
    endtask

    task automatic test_fill_and_walk();
        logic [sstab_pkg::KEY_BITS-1:0] base;
        int                             i;
        no_idle = 1'b1;
        base = $urandom();
        for (i = 0; i < CAPACITY; i++)
            send_request(sstab_pkg::REQ_INSERT, base + i * 3);
        send_request(sstab_pkg::REQ_INSERT, base + 1);
        send_request(sstab_pkg::REQ_INSERT, base);
        send_request(sstab_pkg::REQ_REWIND, $urandom());
        no_idle = 1'b0;
        for (i = 0; i <= CAPACITY; i++)
            send_request(sstab_pkg::REQ_NEXT, $urandom());
        send_request(sstab_pkg::REQ_DELETE, base + 3);
        send_request(sstab_pkg::REQ_INSERT, base + 1);
        send_request(sstab_pkg::REQ_CLEAR, $urandom());
    endtask

    task automatic test_random_requests();
        logic [sstab_pkg::KEY_BITS-1:0] base;
        logic [sstab_pkg::KEY_BITS-1:0] key;
        logic [2:0]                     req;
        int                             pool;
        int                             mode;
        int                             len;
        int                             r;
        int                             i;
        while (items_sent < ITEM_TARGET) begin
            base    = $urandom();
            pool    = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16)
                                                  : $urandom_range(40, 120);
            mode    = $urandom_range(0, 3);
            len     = $urandom_range(20, 120);
            no_idle = ($urandom_range(0, 4) == 0);
            for (i = 0; i < len && items_sent < ITEM_TARGET; i++) begin
                r = $urandom_range(0, 99);
                case (mode)
                    0: req = (r < 70) ? sstab_pkg::REQ_INSERT
                           : (r < 80) ? sstab_pkg::REQ_RETRIEVE
                           : (r < 90) ? sstab_pkg::REQ_NEXT : sstab_pkg::REQ_DELETE;
                    1: req = (r < 60) ? sstab_pkg::REQ_DELETE
                           : (r < 70) ? sstab_pkg::REQ_INSERT
                           : (r < 85) ? sstab_pkg::REQ_RETRIEVE : sstab_pkg::REQ_NEXT;
                    2: req = (r < 10) ? sstab_pkg::REQ_REWIND
                           : (r < 70) ? sstab_pkg::REQ_NEXT
                           : (r < 85) ? sstab_pkg::REQ_INSERT : sstab_pkg::REQ_DELETE;
                    default: req = (r < 25) ? sstab_pkg::REQ_INSERT
                                 : (r < 45) ? sstab_pkg::REQ_DELETE
                                 : (r < 65) ? sstab_pkg::REQ_RETRIEVE
                                 : (r < 75) ? sstab_pkg::REQ_REWIND
                                 : (r < 95) ? sstab_pkg::REQ_NEXT
                                 : (r < 97) ? sstab_pkg::REQ_CLEAR
                                 : (r < 98) ? REQ_SPARE_6 : REQ_SPARE_7;
                endcase
                if ($urandom_range(0, 19) == 0)
                    key = $urandom();
                else
                    key = base + $urandom_range(0, pool);
                send_request(req, key);
            end
        end
    endtask

    initial begin
        start         = 1'b0;
        i_request     = '0;
        i_rst_n       = 1'b0;
        shadow_count  = 0;
        shadow_cursor = 0;
        mismatches    = 0;
        items_sent    = 0;
        no_idle       = 1'b0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_fill_and_walk();
        test_random_requests();

        start = 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/sstab_pkg.sv
sv/sstab_ctrl.sv
sv/sstab_dp.sv
sv/sorted_set_table_top.sv
dv/sorted_set_table_top_tb.sv
